### rtl/core/tkls_pkg.sv
`timescale 1ns / 1ps
// Package for the streaming top-K selector.
// Holds the value width, the per-cell control beat type and the controller states.
// Depends on nothing.
package tkls_pkg;

   // Width of one stream value, two's complement.
   localparam int VALUE_W = 32;

   // Control broadcast from the controller to every cell of the chain.
   typedef struct packed {
      logic insert;   // a new sample is being absorbed this cycle
      logic drain;    // the chain shifts towards cell zero by one place
   } cell_ctrl_type;

   // Controller states, one-hot.
   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_DRAIN = 2'b10
   } tkls_state_type;

endpackage

### rtl/core/tkls_cell.sv
`timescale 1ns / 1ps
// One cell of the sorted insertion chain: holds a single kept value.
// Depends on tkls_pkg for the value width and the control type.
module tkls_cell
   import tkls_pkg::*;
(
   input  logic                       clock,
   input  cell_ctrl_type              ctrl_i,
   input  logic signed [VALUE_W-1:0]  sample_i,
   input  logic                       occupied_i,
   input  logic                       prev_keep_i,
   input  logic signed [VALUE_W-1:0]  prev_value_i,
   input  logic signed [VALUE_W-1:0]  next_value_i,
   output logic                       keep_o,
   output logic signed [VALUE_W-1:0]  value_o
);

   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;

   // The cell keeps its value when it holds one at least as large as the sample;
   // ties stay ahead of the newcomer.
   assign keep_o = occupied_i && (value_ff >= sample_i);

   // Next value: shift towards the head while draining, otherwise either hold,
   // take the sample at the insertion point, or take the neighbour's value.
   always_comb begin
      value_in = value_ff;
      if (ctrl_i.drain) begin
         value_in = next_value_i;
      end else if (ctrl_i.insert && !keep_o) begin
         value_in = prev_keep_i ? sample_i : prev_value_i;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_o = value_ff;

endmodule

### rtl/core/top_k_largest_select_top.sv
`timescale 1ns / 1ps
// Top level of the streaming top-K selector: controller and chain of cells.
// Depends on tkls_pkg and tkls_cell.

// A sample is taken whenever start is high and busy is low, one sample per
// cycle: every cell of the chain compares its kept value with the sample in
// the same cycle and either holds, takes the sample, or takes its neighbour's
// value, so the kept values stay sorted largest first. When a beat marked as
// end of stream has been absorbed, busy rises and the kept values leave on the
// rsp_ ports one per cycle, largest first, each for exactly one cycle under
// rsp_strobe, the smallest with rsp_last_of_run set; the receiver must take a
// result in every cycle it is offered. A stream ending with n kept values
// (n at most KEEP_COUNT) keeps busy high until all n have left, after which the
// store is empty and the next stream may begin.
module top_k_largest_select_top
   import tkls_pkg::*;
#(
   parameter int KEEP_COUNT = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [VALUE_W-1:0] req_sample_value,
   input  logic                      req_end_of_stream,
   output logic                      rsp_strobe,
   output logic signed [VALUE_W-1:0] rsp_kept_value,
   output logic                      rsp_last_of_run
);

   localparam int FILL_W = $clog2(KEEP_COUNT + 1);

   tkls_state_type state_ff, state_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic accept;
   cell_ctrl_type ctrl;

   logic                      keep   [KEEP_COUNT];
   logic signed [VALUE_W-1:0] values [KEEP_COUNT];

   assign busy   = (state_ff == ST_DRAIN);
   assign accept = start && !busy;

   assign ctrl.insert = accept;
   assign ctrl.drain  = busy;

   // Controller: fill count during collection, remaining count during drain.
   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (fill_ff < FILL_W'(KEEP_COUNT)) begin
                  fill_in = fill_ff + FILL_W'(1);
               end
               if (req_end_of_stream) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            fill_in = fill_ff - FILL_W'(1);
            if (fill_ff == FILL_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            fill_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
   end

   // The chain: cell zero holds the largest kept value.
   for (genvar i = 0; i < KEEP_COUNT; i++) begin : g_cell
      logic                      occupied;
      logic                      prev_keep;
      logic signed [VALUE_W-1:0] prev_value;
      logic signed [VALUE_W-1:0] next_value;

      assign occupied = (fill_ff > FILL_W'(i));

      if (i == 0) begin : g_head
         assign prev_keep  = 1'b1;
         assign prev_value = req_sample_value;
      end else begin : g_body
         assign prev_keep  = keep[i-1];
         assign prev_value = values[i-1];
      end

      if (i == KEEP_COUNT - 1) begin : g_tail
         assign next_value = values[i];
      end else begin : g_inner
         assign next_value = values[i+1];
      end

      tkls_cell u_cell (
         .clock        (clock),
         .ctrl_i       (ctrl),
         .sample_i     (req_sample_value),
         .occupied_i   (occupied),
         .prev_keep_i  (prev_keep),
         .prev_value_i (prev_value),
         .next_value_i (next_value),
         .keep_o       (keep[i]),
         .value_o      (values[i])
      );
   end

   // Results leave from the head of the chain, one beat per drain cycle.
   assign rsp_strobe      = busy;
   assign rsp_kept_value  = values[0];
   assign rsp_last_of_run = busy && (fill_ff == FILL_W'(1));

endmodule

### sim/top_k_largest_select_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the streaming top-K selector: it watches the sample and result channels,
// keeps its own sorted store to predict each drained run, and counts mismatches.
// Depends on tkls_pkg for the value width.
module top_k_largest_select_checker
   import tkls_pkg::*;
#(
   parameter int KEEP_COUNT = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic signed [VALUE_W-1:0] req_sample_value,
   input  logic                      req_end_of_stream,
   input  logic                      rsp_strobe,
   input  logic signed [VALUE_W-1:0] rsp_kept_value,
   input  logic                      rsp_last_of_run,
   output int                        fail_count,
   output int                        results_outstanding
);

   typedef struct {
      logic signed [VALUE_W-1:0] value;
      logic                      last_flag;
   } kept_result_type;

   // Predicted store, largest value first, and its fill level.
   logic signed [VALUE_W-1:0] top_values [KEEP_COUNT];
   int                        top_fill = 0;

   // Results that the block still owes, oldest first.
   kept_result_type drain_queue [$];

   initial fail_count = 0;
   assign results_outstanding = drain_queue.size();

   // Only the first ten failures are described; the rest are counted.
   function automatic void note_failure(input string what, input logic [VALUE_W-1:0] wanted,
                                        input logic [VALUE_W-1:0] seen);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t ns: %s mismatch: expected %0d (0x%08h), got %0d (0x%08h)", $time,
                  what, $signed(wanted), wanted, $signed(seen), seen);
      end
   endfunction

   // Insert one sample into the sorted store. Once full, a sample must beat the
   // smallest kept value strictly, and that value falls off the end.
   function automatic void absorb_sample(input logic signed [VALUE_W-1:0] sample);
      int slot;
      int end_slot;
      if (top_fill == KEEP_COUNT) begin
         if (!(sample > top_values[KEEP_COUNT-1])) return;
         end_slot = KEEP_COUNT - 1;
      end else begin
         end_slot = top_fill;
         top_fill++;
      end
      slot = 0;
      while (slot < end_slot && top_values[slot] >= sample) slot++;
      for (int i = end_slot; i > slot; i--) top_values[i] = top_values[i-1];
      top_values[slot] = sample;
   endfunction

   // An end-of-stream beat drains the whole store, largest first, then empties it.
   function automatic void queue_drain();
      kept_result_type entry;
      for (int i = 0; i < top_fill; i++) begin
         entry.value     = top_values[i];
         entry.last_flag = (i == top_fill - 1);
         drain_queue     = {drain_queue, entry};
      end
      top_fill = 0;
   endfunction

   always @(posedge clock) begin
      kept_result_type wanted;
      if (reset !== 1'b1) begin
         // Result side: every strobed beat must match the oldest prediction.
         if (rsp_strobe === 1'b1) begin
            if (drain_queue.size() == 0) begin
               note_failure("unexpected result, kept value", '0, rsp_kept_value);
            end else begin
               wanted = drain_queue.pop_front();
               if (rsp_kept_value !== wanted.value)
                  note_failure("kept value", wanted.value, rsp_kept_value);
               if (rsp_last_of_run !== wanted.last_flag)
                  note_failure("last of run", {{(VALUE_W-1){1'b0}}, wanted.last_flag},
                               {{(VALUE_W-1){1'b0}}, rsp_last_of_run});
            end
         end
         // Sample side: a beat is taken when start is high and busy is low.
         if (start === 1'b1 && busy === 1'b0) begin
            absorb_sample(req_sample_value);
            if (req_end_of_stream === 1'b1) queue_drain();
         end
      end
   end

endmodule

### sim/top_k_largest_select_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the streaming top-K selector: clock, reset, sample stimulus and verdict.
// Depends on tkls_pkg, top_k_largest_select_top and top_k_largest_select_checker.
module top_k_largest_select_top_tb
   import tkls_pkg::*;
();

   localparam int KEEP_COUNT  = 10;
   localparam int ITEM_COUNT  = 110;
   localparam int CYCLE_LIMIT = 200000;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic signed [VALUE_W-1:0] req_sample_value = '0;
   logic                      req_end_of_stream = 1'b0;
   logic                      rsp_strobe;
   logic signed [VALUE_W-1:0] rsp_kept_value;
   logic                      rsp_last_of_run;

   int   fail_count;
   int   results_outstanding;
   int   cycle_count = 0;
   int   samples_sent = 0;
   logic back_to_back = 1'b0;

   top_k_largest_select_top #(.KEEP_COUNT(KEEP_COUNT)) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_sample_value  (req_sample_value),
      .req_end_of_stream (req_end_of_stream),
      .rsp_strobe        (rsp_strobe),
      .rsp_kept_value    (rsp_kept_value),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   top_k_largest_select_checker #(.KEEP_COUNT(KEEP_COUNT)) checker_inst (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_sample_value    (req_sample_value),
      .req_end_of_stream   (req_end_of_stream),
      .rsp_strobe          (rsp_strobe),
      .rsp_kept_value      (rsp_kept_value),
      .rsp_last_of_run     (rsp_last_of_run),
      .fail_count          (fail_count),
      .results_outstanding (results_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Idle cycles before the next beat; bursts of streams run with none at all.
   function automatic int next_gap();
      if (back_to_back) return 0;
      return $urandom_range(0, 17);
   endfunction

   // Mix of fully random values, a narrow band that makes ties, and the extremes.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      int band;
      band = $urandom_range(0, 16);
      case ($urandom_range(0, 3))
         0: return band - 8;
         1: begin
            case ($urandom_range(0, 3))
               0: return 32'sh7FFF_FFFF;
               1: return 32'sh8000_0000;
               2: return -32'sd1;
               default: return 32'sd0;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   // Offer one beat from a falling edge and hold it until the block takes it.
   // Start stays high on return so that a zero gap gives back-to-back beats.
   task automatic drive_sample(input logic signed [VALUE_W-1:0] sample, input logic eos);
      int gap;
      gap = next_gap();
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start             = 1'b1;
      req_sample_value  = sample;
      req_end_of_stream = eos;
      do @(posedge clock); while (busy !== 1'b0);
      samples_sent++;
      @(negedge clock);
   endtask

   // One random stream of the given length; only its final beat ends the stream.
   task automatic drive_stream(input int length);
      for (int i = 0; i < length; i++) drive_sample(pick_value(), i == length - 1);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Shortest possible stream: a single most-negative value.
      drive_sample(32'sh8000_0000, 1'b1);
      // Short stream with the largest value arriving last.
      drive_sample(32'sd0, 1'b0);
      drive_sample(-32'sd1, 1'b0);
      drive_sample(32'sh7FFF_FFFF, 1'b1);
      // Full store of equal values: a further tie is dropped, a larger one enters.
      for (int i = 0; i < KEEP_COUNT + 1; i++) drive_sample(32'sd7, 1'b0);
      drive_sample(32'sd8, 1'b1);
      // Alternating bit patterns and both extremes, so every bit takes both values.
      back_to_back = 1'b1;
      drive_sample(32'sh7FFF_FFFF, 1'b0);
      drive_sample(32'sh8000_0000, 1'b0);
      drive_sample(32'sh5555_5555, 1'b0);
      drive_sample(32'shAAAA_AAAA, 1'b0);
      drive_sample(-32'sd1, 1'b0);
      drive_sample(32'sd0, 1'b1);

      // Random streams until the whole run has sent about ITEM_COUNT beats:
      // short ones, ones that just fill the store and long ones.
      while (samples_sent < ITEM_COUNT) begin
         back_to_back = ($urandom_range(0, 2) == 0);
         case ($urandom_range(0, 2))
            0: drive_stream($urandom_range(1, KEEP_COUNT - 1));
            1: drive_stream($urandom_range(KEEP_COUNT, KEEP_COUNT + 1));
            default: drive_stream($urandom_range(KEEP_COUNT + 2, 2 * KEEP_COUNT + 5));
         endcase
      end
      start = 1'b0;

      // Let the last drain finish, then watch for stray strobes before the verdict.
      while (results_outstanding != 0) @(negedge clock);
      repeat (KEEP_COUNT + 4) @(negedge clock);
      if (fail_count == 0 && results_outstanding == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/tkls_pkg.sv
rtl/core/tkls_cell.sv
rtl/core/top_k_largest_select_top.sv
sim/top_k_largest_select_checker.sv
sim/top_k_largest_select_top_tb.sv
